@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rba_pkg;

  localparam int DEV_W = 4;
  localparam int MEM_W = 11;
  localparam int OFF_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_PRINTERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCANNERS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODEMS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CDS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RT_MEM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USER_MEM = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
  localparam logic [1:0] PRIO_REALTIME = 2'd0;

  localparam logic [DEV_W-1:0] DEV_MAX = 4'd15;
  localparam logic [MEM_W-1:0] MEM_MAX = 11'd2047;

  localparam logic [DEV_W-1:0] RST_PRINTERS = 4'd2;
  localparam logic [DEV_W-1:0] RST_SCANNERS = 4'd1;
  localparam logic [DEV_W-1:0] RST_MODEMS = 4'd1;
  localparam logic [DEV_W-1:0] RST_CDS = 4'd2;
  localparam logic [MEM_W-1:0] RST_RT_MEM = 11'd64;
  localparam logic [MEM_W-1:0] RST_USER_MEM = 11'd960;

  typedef struct packed {
    logic             op;
    logic [1:0]       priority_req;
    logic [MEM_W-1:0] mbytes;
    logic [DEV_W-1:0] printers_needed;
    logic [DEV_W-1:0] scanners_needed;
    logic [DEV_W-1:0] modems_needed;
    logic [DEV_W-1:0] cds_needed;
    logic [OFF_W-1:0] release_offset;
    logic             release_placed;
  } req_t;

  typedef struct packed {
    logic             granted;
    logic             placed;
    logic [OFF_W-1:0] offset_mb;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic scan;
    logic mark;
    logic sweep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic alloc_go;
    logic free_go;
    logic hit;
    logic last;
    logic mark_end;
    logic sweep_end;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/rba_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rba_dp
  import rba_pkg::*;
#(
  parameter int NUM_BLOCKS = 32,
  parameter int BLOCK_MB = 32,
  parameter int REALTIME_BLOCKS = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire req_t                 in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output rsp_t                      out_data
);

  localparam int RT_END = (REALTIME_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS : REALTIME_BLOCKS;
  localparam bit USER_EMPTY = (RT_END == NUM_BLOCKS);
  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int AW = $clog2(NUM_BLOCKS * BLOCK_MB + 2048) + 1;
  localparam logic [AW-1:0] BLK = AW'(BLOCK_MB);
  localparam logic [AW-1:0] RT_BASE = AW'(RT_END * BLOCK_MB);
  localparam logic [IW-1:0] RT_FIRST = IW'(RT_END);
  localparam logic [IW-1:0] RT_LAST = IW'(RT_END - 1);
  localparam logic [IW-1:0] LAST_BLK = IW'(NUM_BLOCKS - 1);
  localparam logic [IW-1:0] ONE_BLK = IW'(1);

  function automatic logic [DEV_W-1:0] sat_dev(input logic [DEV_W-1:0] a,
                                               input logic [DEV_W-1:0] b);
    logic [DEV_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DEV_W] ? DEV_MAX : s[DEV_W-1:0];
  endfunction

  function automatic logic [MEM_W-1:0] sat_mem(input logic [MEM_W-1:0] a,
                                               input logic [MEM_W-1:0] b);
    logic [MEM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[MEM_W] ? MEM_MAX : s[MEM_W-1:0];
  endfunction

  logic [DEV_W-1:0]      free_printers;
  logic [DEV_W-1:0]      free_scanners;
  logic [DEV_W-1:0]      free_modems;
  logic [DEV_W-1:0]      free_cds;
  logic [MEM_W-1:0]      rt_free;
  logic [MEM_W-1:0]      user_free;
  logic [NUM_BLOCKS-1:0] used;

  req_t          req;
  logic [IW-1:0] b;
  logic [IW-1:0] hi_last;
  logic [IW-1:0] start_blk;
  logic [IW-1:0] end_blk;
  logic [AW-1:0] base;
  logic [AW-1:0] run;
  logic [AW-1:0] start_base;
  logic [AW-1:0] rel;
  logic          found;
  logic          granted;
  logic          placed;
  rsp_t          rsp;

  logic             rt;
  logic [MEM_W-1:0] memfree;
  logic             fits;
  logic             region_ok;
  logic [IW-1:0]    lo_blk;
  logic [AW-1:0]    lo_base;
  logic [IW-1:0]    hi_last_w;
  logic [AW-1:0]    mb_ext;
  logic [AW-1:0]    roff_ext;
  logic [AW-1:0]    run_add;
  logic             scan_hit;
  logic             hit_now;
  logic             in_run;
  logic [AW-1:0]    rel_next;

  always_comb begin
    rt = (req.priority_req == PRIO_REALTIME);
    memfree = rt ? rt_free : user_free;
    fits = (free_printers >= req.printers_needed) && (free_scanners >= req.scanners_needed) &&
           (free_modems >= req.modems_needed) && (free_cds >= req.cds_needed) &&
           (memfree >= req.mbytes);
    region_ok = rt || !USER_EMPTY;
    lo_blk = rt ? '0 : RT_FIRST;
    lo_base = rt ? '0 : RT_BASE;
    hi_last_w = rt ? RT_LAST : LAST_BLK;
    mb_ext = AW'(req.mbytes);
    roff_ext = AW'(req.release_offset);

    run_add = run + BLK;
    scan_hit = !used[b] && (run_add >= mb_ext);

    hit_now = !found && (roff_ext < base + BLK);
    in_run = (hit_now || found) && (rel < mb_ext);
    rel_next = hit_now ? BLK : rel + BLK;

    status.alloc_go = (req.op == OP_ALLOC) && fits && (req.mbytes != '0) && region_ok;
    status.free_go = (req.op == OP_RELEASE) && req.release_placed && (req.mbytes != '0) &&
                     region_ok && (roff_ext >= lo_base);
    status.hit = scan_hit;
    status.last = (b == hi_last);
    status.mark_end = (b == end_blk);
    status.sweep_end = (b == hi_last) || ((hit_now || found) && (rel_next >= mb_ext));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_printers <= RST_PRINTERS;
      free_scanners <= RST_SCANNERS;
      free_modems <= RST_MODEMS;
      free_cds <= RST_CDS;
      rt_free <= RST_RT_MEM;
      user_free <= RST_USER_MEM;
      used <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PRINTERS: free_printers <= cfg_data[DEV_W-1:0];
          REG_SCANNERS: free_scanners <= cfg_data[DEV_W-1:0];
          REG_MODEMS: free_modems <= cfg_data[DEV_W-1:0];
          REG_CDS: free_cds <= cfg_data[DEV_W-1:0];
          REG_RT_MEM: rt_free <= cfg_data[MEM_W-1:0];
          REG_USER_MEM: user_free <= cfg_data[MEM_W-1:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        if (req.op == OP_RELEASE) begin
          free_printers <= sat_dev(free_printers, req.printers_needed);
          free_scanners <= sat_dev(free_scanners, req.scanners_needed);
          free_modems <= sat_dev(free_modems, req.modems_needed);
          free_cds <= sat_dev(free_cds, req.cds_needed);
          if (rt) begin
            rt_free <= sat_mem(rt_free, req.mbytes);
          end else begin
            user_free <= sat_mem(user_free, req.mbytes);
          end
        end else if (fits) begin
          free_printers <= free_printers - req.printers_needed;
          free_scanners <= free_scanners - req.scanners_needed;
          free_modems <= free_modems - req.modems_needed;
          free_cds <= free_cds - req.cds_needed;
          if (rt) begin
            rt_free <= rt_free - req.mbytes;
          end else begin
            user_free <= user_free - req.mbytes;
          end
        end
      end
      if (cmd.mark) begin
        used[b] <= 1'b1;
      end
      if (cmd.sweep && in_run) begin
        used[b] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
    if (cmd.eval) begin
      granted <= (req.op == OP_RELEASE) || fits;
      placed <= 1'b0;
      found <= 1'b0;
      rel <= '0;
      run <= '0;
      b <= lo_blk;
      start_blk <= lo_blk;
      hi_last <= hi_last_w;
      base <= lo_base;
      start_base <= lo_base;
    end else if (cmd.scan) begin
      b <= scan_hit ? start_blk : b + ONE_BLK;
      base <= base + BLK;
      if (used[b]) begin
        run <= '0;
        start_blk <= b + ONE_BLK;
        start_base <= base + BLK;
      end else begin
        run <= run_add;
      end
      if (scan_hit) begin
        end_blk <= b;
        placed <= 1'b1;
      end
    end else if (cmd.mark) begin
      b <= b + ONE_BLK;
    end else if (cmd.sweep) begin
      b <= b + ONE_BLK;
      base <= base + BLK;
      if (hit_now) begin
        found <= 1'b1;
      end
      if (hit_now || found) begin
        rel <= rel_next;
      end
    end
    if (cmd.emit) begin
      rsp.granted <= granted;
      rsp.placed <= placed;
      rsp.offset_mb <= placed ? start_base[OFF_W-1:0] : '0;
    end
  end

  assign out_data = rsp;

endmodule

`default_nettype wire

@@ rtl/rba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rba_ctrl
  import rba_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cmd_t         cmd,
  input  wire status_t status
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.alloc_go) begin
          state_next = ST_SCAN;
        end else if (status.free_go) begin
          state_next = ST_FREE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          state_next = ST_MARK;
        end else if (status.last) begin
          state_next = ST_DONE;
        end
      end
      ST_MARK: begin
        cmd.mark = 1'b1;
        if (status.mark_end) begin
          state_next = ST_DONE;
        end
      end
      ST_FREE: begin
        cmd.sweep = 1'b1;
        if (status.sweep_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

endmodule

`default_nettype wire

@@ rtl/resource_and_block_allocator.sv @@
// A refused request, a grant without memory or a release without a run goes from idle through
// evaluate to done and gives its result word; a grant with memory first scans blocks and then
// marks the blocks of a placed run, and a release with a run first sweeps blocks to free it.
// One word is in work at a time; the next is taken in the cycle after the result is loaded.
// Reset restores the default device and memory counts and marks every block free at once.
`timescale 1ns / 1ps
`default_nettype none

module resource_and_block_allocator
  import rba_pkg::*;
#(
  parameter int NUM_BLOCKS = 32,
  parameter int BLOCK_MB = 32,
  parameter int REALTIME_BLOCKS = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire req_t                 in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rsp_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  rba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  rba_dp #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .BLOCK_MB        (BLOCK_MB),
    .REALTIME_BLOCKS (REALTIME_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/rba_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rba_checker
  import rba_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire rsp_t out_data
);

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled output word changed")
  `ASSERT_CLK(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "input taken while a word is in work")
  `ASSERT_CLK(a_result_after_work, $rose(out_valid) |-> $past(!in_ready), "result word without a word in work")
  `ASSERT_CLK(a_placed_granted, out_valid && !out_data.granted |-> !out_data.placed && out_data.offset_mb == '0, "refused word carries a placement")

endmodule

bind resource_and_block_allocator rba_checker u_rba_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rba_pkg::*;

  localparam int NBLK = 32;
  localparam int BLK_MB = 32;
  localparam int RT_BLK = 2;
  localparam int RT_END = (RT_BLK > NBLK) ? NBLK : RT_BLK;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 219;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PRINTERS;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [DEV_W-1:0] free_prn, free_scn, free_mdm, free_cd;
  logic [MEM_W-1:0] rt_mem_free, user_mem_free;
  logic [NBLK-1:0] block_map;

  req_t req_q[$];
  rsp_t expected_words[$];
  // Release words that give back grants still outstanding.
  req_t live_grants[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  resource_and_block_allocator #(
    .NUM_BLOCKS(NBLK),
    .BLOCK_MB(BLK_MB),
    .REALTIME_BLOCKS(RT_BLK)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int sat_sum(int a, int b, int top);
    return (a + b > top) ? top : a + b;
  endfunction

  function automatic rsp_t allocate_or_release(req_t r);
    rsp_t res;
    logic rt;
    logic fits;
    logic [MEM_W-1:0] mem_left;
    int lo, hi, nblk, s, k;
    res = '0;
    rt = (r.priority_req == PRIO_REALTIME);
    lo = rt ? 0 : RT_END;
    hi = rt ? RT_END : NBLK;
    nblk = (int'(r.mbytes) + BLK_MB - 1) / BLK_MB;
    if (r.op == OP_ALLOC) begin
      mem_left = rt ? rt_mem_free : user_mem_free;
      if (free_prn >= r.printers_needed && free_scn >= r.scanners_needed &&
          free_mdm >= r.modems_needed && free_cd >= r.cds_needed &&
          mem_left >= r.mbytes) begin
        res.granted = 1'b1;
        free_prn = free_prn - r.printers_needed;
        free_scn = free_scn - r.scanners_needed;
        free_mdm = free_mdm - r.modems_needed;
        free_cd = free_cd - r.cds_needed;
        if (rt) begin
          rt_mem_free = rt_mem_free - r.mbytes;
        end else begin
          user_mem_free = user_mem_free - r.mbytes;
        end
        if (nblk > 0 && nblk <= hi - lo) begin
          for (s = lo; s + nblk <= hi && !res.placed; s++) begin
            fits = 1'b1;
            for (k = 0; k < nblk; k++) begin
              if (block_map[s + k]) fits = 1'b0;
            end
            if (fits) begin
              for (k = 0; k < nblk; k++) block_map[s + k] = 1'b1;
              res.placed = 1'b1;
              res.offset_mb = OFF_W'(s * BLK_MB);
            end
          end
        end
      end
    end else begin
      res.granted = 1'b1;
      free_prn = DEV_W'(sat_sum(free_prn, r.printers_needed, DEV_MAX));
      free_scn = DEV_W'(sat_sum(free_scn, r.scanners_needed, DEV_MAX));
      free_mdm = DEV_W'(sat_sum(free_mdm, r.modems_needed, DEV_MAX));
      free_cd = DEV_W'(sat_sum(free_cd, r.cds_needed, DEV_MAX));
      if (rt) begin
        rt_mem_free = MEM_W'(sat_sum(rt_mem_free, r.mbytes, MEM_MAX));
      end else begin
        user_mem_free = MEM_W'(sat_sum(user_mem_free, r.mbytes, MEM_MAX));
      end
      if (r.release_placed) begin
        s = int'(r.release_offset) / BLK_MB;
        if (s >= lo && s < hi) begin
          for (k = 0; k < nblk && s + k < hi; k++) block_map[s + k] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  function automatic req_t make_req(logic op, logic [1:0] prio, int mb, int p, int s,
                                    int m, int c, int roff, logic rplaced);
    req_t r;
    r.op = op;
    r.priority_req = prio;
    r.mbytes = MEM_W'(mb);
    r.printers_needed = DEV_W'(p);
    r.scanners_needed = DEV_W'(s);
    r.modems_needed = DEV_W'(m);
    r.cds_needed = DEV_W'(c);
    r.release_offset = OFF_W'(roff);
    r.release_placed = rplaced;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("%0t ns: %s got %0h, want %0h", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    case (idx)
      REG_PRINTERS: free_prn = DEV_W'(val);
      REG_SCANNERS: free_scn = DEV_W'(val);
      REG_MODEMS: free_mdm = DEV_W'(val);
      REG_CDS: free_cd = DEV_W'(val);
      REG_RT_MEM: rt_mem_free = MEM_W'(val);
      REG_USER_MEM: user_mem_free = MEM_W'(val);
      default: ;
    endcase
  endtask

  task automatic program_regs(int p, int s, int m, int c, int rt_mb, int user_mb);
    write_reg(REG_PRINTERS, p);
    write_reg(REG_SCANNERS, s);
    write_reg(REG_MODEMS, m);
    write_reg(REG_CDS, c);
    write_reg(REG_RT_MEM, rt_mb);
    write_reg(REG_USER_MEM, user_mb);
    write_reg(REG_SPARE_LO, $urandom_range(2047));
    write_reg(REG_SPARE_HI, $urandom_range(2047));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic enqueue(req_t r);
    @(negedge clk);
    while (req_q.size() > 0) @(negedge clk);
    req_q.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    while (req_q.size() > 0 || in_valid || expected_words.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    req_t undo;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want = allocate_or_release(in_data);
        expected_words.push_back(want);
        if (in_data.op == OP_ALLOC && want.granted) begin
          undo = in_data;
          undo.op = OP_RELEASE;
          undo.release_offset = want.offset_mb;
          undo.release_placed = want.placed;
          live_grants.push_back(undo);
        end
      end
      if (!in_valid || in_ready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_data, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_data.granted !== want.granted) begin
            report_mismatch("granted", out_data.granted, want.granted);
          end
          if (out_data.placed !== want.placed) begin
            report_mismatch("placed", out_data.placed, want.placed);
          end
          if (out_data.offset_mb !== want.offset_mb) begin
            report_mismatch("offset_mb", out_data.offset_mb, want.offset_mb);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("resource_and_block_allocator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_t r;
    int ph, i, pick, idx, mb, size_class, dev_top;
    free_prn = RST_PRINTERS;
    free_scn = RST_SCANNERS;
    free_mdm = RST_MODEMS;
    free_cd = RST_CDS;
    rt_mem_free = RST_RT_MEM;
    user_mem_free = RST_USER_MEM;
    block_map = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    enqueue(make_req(OP_ALLOC, 2'd0, 64, 1, 1, 1, 1, 0, 1'b0));
    enqueue(make_req(OP_ALLOC, 2'd0, 1, 0, 0, 0, 0, 1023, 1'b1));
    enqueue(make_req(OP_ALLOC, 2'd1, 0, 0, 0, 0, 0, 0, 1'b0));
    enqueue(make_req(OP_ALLOC, 2'd2, 32, 15, 15, 15, 15, 0, 1'b0));
    enqueue(make_req(OP_ALLOC, 2'd3, 960, 1, 0, 0, 1, 0, 1'b0));
    enqueue(make_req(OP_RELEASE, 2'd3, 960, 0, 0, 0, 0, 0, 1'b0));
    enqueue(make_req(OP_ALLOC, 2'd1, 33, 0, 0, 0, 0, 0, 1'b0));
    enqueue(make_req(OP_RELEASE, 2'd2, 1024, 15, 15, 15, 15, 0, 1'b0));
    enqueue(make_req(OP_RELEASE, 2'd1, 1024, 15, 15, 15, 15, 0, 1'b0));
    enqueue(make_req(OP_RELEASE, 2'd0, 64, 0, 0, 0, 0, 1023, 1'b1));
    enqueue(make_req(OP_RELEASE, 2'd1, 1024, 0, 0, 0, 0, 992, 1'b1));
    enqueue(make_req(OP_ALLOC, 2'd2, 32, 0, 0, 0, 0, 0, 1'b0));
    enqueue(make_req(OP_RELEASE, 2'd3, 960, 0, 0, 0, 0, 64, 1'b1));
    enqueue(make_req(OP_RELEASE, 2'd0, 64, 0, 0, 0, 0, 0, 1'b1));
    enqueue(make_req(OP_RELEASE, 2'd1, 32, 0, 0, 0, 0, 0, 1'b1));
    enqueue(make_req(OP_ALLOC, 2'd0, 33, 1, 1, 1, 1, 0, 1'b0));
    enqueue(make_req(OP_ALLOC, 2'd1, 1024, 0, 0, 0, 0, 0, 1'b0));
    enqueue(make_req(OP_ALLOC, 2'd3, 1023, 0, 0, 0, 0, 1023, 1'b1));
    enqueue(make_req(OP_ALLOC, 2'd1, 1, 0, 0, 0, 0, 0, 1'b0));
    enqueue(make_req(OP_RELEASE, 2'd2, 0, 0, 0, 0, 0, 1023, 1'b0));

    for (ph = 1; ph <= PHASES; ph++) begin
      drain();
      case (ph)
        1: program_regs(15, 15, 15, 15, 1024, 1024);
        2: program_regs(0, 0, 0, 0, 0, 0);
        3: program_regs(RST_PRINTERS, RST_SCANNERS, RST_MODEMS, RST_CDS,
                        RST_RT_MEM, RST_USER_MEM);
        default: program_regs($urandom_range(15), $urandom_range(15), $urandom_range(15),
                              $urandom_range(15), $urandom_range(1024),
                              $urandom_range(1024));
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 49;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct = 13;
        end
      endcase
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          r = make_req($urandom_range(1), $urandom_range(3), $urandom_range(1024),
                       $urandom_range(15), $urandom_range(15), $urandom_range(15),
                       $urandom_range(15), $urandom_range(1023), $urandom_range(1));
        end else if (live_grants.size() > 0 && (pick < 50 || live_grants.size() > 24)) begin
          idx = $urandom_range(live_grants.size() - 1);
          r = live_grants[idx];
          live_grants.delete(idx);
        end else begin
          size_class = $urandom_range(19);
          if (size_class == 0) begin
            mb = $urandom_range(1024);
          end else if (size_class < 6) begin
            mb = $urandom_range(320);
          end else begin
            mb = $urandom_range(96);
          end
          dev_top = ($urandom_range(9) == 0) ? 15 : 2;
          r = make_req(OP_ALLOC, $urandom_range(3), mb, $urandom_range(dev_top),
                       $urandom_range(dev_top), $urandom_range(dev_top),
                       $urandom_range(dev_top), $urandom_range(1023), $urandom_range(1));
        end
        enqueue(r);
        if ($urandom_range(99) == 0) drain();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("resource_and_block_allocator: match");
    end else begin
      $display("resource_and_block_allocator: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rba_pkg.sv
rtl/rba_dp.sv
rtl/rba_ctrl.sv
rtl/resource_and_block_allocator.sv
rtl/rba_checker.sv
dv/testbench.sv
